### rtl/bss_pkg.sv
// Shared constants, operation codes and result type of the sparse set.
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

    localparam int UNIVERSE = 1024;
    localparam int ELEM_W   = $clog2(UNIVERSE);
    localparam int CNT_W    = $clog2(UNIVERSE + 1);
    localparam int KIND_W   = 4;

    localparam logic [CNT_W-1:0]  NEVER_ADDED = CNT_W'(UNIVERSE);
    localparam logic [ELEM_W-1:0] LAST_IDX    = ELEM_W'(UNIVERSE - 1);

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        K_ADD      = 4'd0,
        K_REMOVE   = 4'd1,
        K_CONTAIN  = 4'd2,
        K_RESTORE  = 4'd3,
        K_CLEAR    = 4'd4,
        K_FILL     = 4'd5,
        K_POP_BACK = 4'd6,
        K_POP_HEAD = 4'd7,
        K_NEXT     = 4'd8,
        K_PREV     = 4'd9,
        K_READ_AT  = 4'd10,
        K_MOVE_UP  = 4'd11
    } kind_t;

    typedef struct packed {
        logic              status;
        logic              found;
        logic [ELEM_W-1:0] value;
        logic [CNT_W-1:0]  active_size;
        logic [CNT_W-1:0]  stored_length;
    } res_t;

endpackage

`default_nettype wire

### rtl/bss_if.sv
// Request and response channel interfaces of the sparse set.
`timescale 1ns / 1ps
`default_nettype none

interface bss_in_if;
    logic                              valid;
    logic                              ready;
    logic [bss_pkg::KIND_W-1:0]        kind;
    logic [bss_pkg::ELEM_W-1:0]        element;
    logic [bss_pkg::CNT_W-1:0]         position;

    modport source (output valid, output kind, output element, output position, input ready);
    modport sink   (input valid, input kind, input element, input position, output ready);
endinterface

interface bss_out_if;
    logic                              valid;
    logic                              ready;
    logic                              status;
    logic                              found;
    logic [bss_pkg::ELEM_W-1:0]        value;
    logic [bss_pkg::CNT_W-1:0]         active_size;
    logic [bss_pkg::CNT_W-1:0]         stored_length;

    modport source (output valid, output status, output found, output value,
                    output active_size, output stored_length, input ready);
    modport sink   (input valid, input status, input found, input value,
                    input active_size, input stored_length, output ready);
endinterface

`default_nettype wire

### rtl/bss_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bss_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/bss_outq.sv
// Two-entry response buffer: output register plus skid entry.
`timescale 1ns / 1ps
`default_nettype none

module bss_outq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire bss_pkg::res_t din,
    output logic               room,
    bss_out_if.source          rsp
);

    logic          out_v_reg;
    logic          skid_v_reg;
    bss_pkg::res_t out_reg;
    bss_pkg::res_t skid_reg;
    logic          out_free;

    assign out_free = !out_v_reg || rsp.ready;
    assign room     = !skid_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_v_reg  <= skid_v_reg || push;
            skid_v_reg <= skid_v_reg && push;
        end
        else if (push)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_v_reg)
            begin
                out_reg <= skid_reg;
                if (push)
                begin
                    skid_reg <= din;
                end
            end
            else if (push)
            begin
                out_reg <= din;
            end
        end
        else if (push)
        begin
            skid_reg <= din;
        end
    end

    assign rsp.valid         = out_v_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.found         = out_reg.found;
    assign rsp.value         = out_reg.value;
    assign rsp.active_size   = out_reg.active_size;
    assign rsp.stored_length = out_reg.stored_length;

endmodule

`default_nettype wire

### rtl/bss_ctrl.sv
// Sequencer: reads, checks and swaps entries of the slot and list memories.
`timescale 1ns / 1ps
`default_nettype none

module bss_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    bss_in_if.sink                             req,
    input  wire logic                          room,
    output logic                               push,
    output bss_pkg::res_t                      res,
    output logic                               s_we,
    output logic [bss_pkg::ELEM_W-1:0]         s_waddr,
    output logic [bss_pkg::CNT_W-1:0]          s_wdata,
    output logic                               s_re,
    output logic [bss_pkg::ELEM_W-1:0]         s_raddr,
    input  wire logic [bss_pkg::CNT_W-1:0]     s_rdata,
    output logic                               l_we,
    output logic [bss_pkg::ELEM_W-1:0]         l_waddr,
    output logic [bss_pkg::ELEM_W-1:0]         l_wdata,
    output logic                               l_re,
    output logic [bss_pkg::ELEM_W-1:0]         l_raddr,
    input  wire logic [bss_pkg::ELEM_W-1:0]    l_rdata
);

    localparam int EW = bss_pkg::ELEM_W;
    localparam int CW = bss_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD2,
        ST_EXEC,
        ST_WR2
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [EW-1:0]              clr_idx_reg;
    logic [CW-1:0]              act_reg;
    logic [CW-1:0]              act_next;
    logic [CW-1:0]              app_reg;
    logic [CW-1:0]              app_next;
    logic [bss_pkg::KIND_W-1:0] kind_reg;
    logic [EW-1:0]              elem_reg;
    logic [CW-1:0]              pos_reg;
    logic [CW-1:0]              slot_reg;
    logic [EW-1:0]              ld1_reg;
    logic [EW-1:0]              w2_addr_reg;
    logic [EW-1:0]              w2_elem_reg;

    logic          acc;
    logic [CW-1:0] act_m1;
    logic [CW-1:0] rd_slot_p1;
    logic [CW-1:0] rd_slot_m1;
    logic [CW-1:0] slot_p1;
    logic          stored;
    logic          member;
    logic          swap_en;
    logic [EW-1:0] sw_x;
    logic [EW-1:0] sw_y;
    logic [EW-1:0] sw_ex;
    logic [EW-1:0] sw_ey;

    assign req.ready = (state_reg == ST_IDLE) && room;
    assign acc       = req.valid && req.ready;
    assign act_m1    = act_reg - CW'(1);
    assign rd_slot_p1 = s_rdata + CW'(1);
    assign rd_slot_m1 = s_rdata - CW'(1);
    assign slot_p1   = slot_reg + CW'(1);
    assign stored    = slot_reg != bss_pkg::NEVER_ADDED;
    assign member    = stored && (slot_reg < act_reg);
    assign push      = (state_reg == ST_EXEC);

    // Decide the operation once slot and list data are in.
    always_comb
    begin
        res.status        = bss_pkg::STATUS_OK;
        res.found         = 1'b0;
        res.value         = '0;
        act_next          = act_reg;
        app_next          = app_reg;
        swap_en           = 1'b0;
        sw_x              = slot_reg[EW-1:0];
        sw_y              = act_reg[EW-1:0];
        sw_ex             = elem_reg;
        sw_ey             = ld1_reg;
        case (kind_reg)
            bss_pkg::K_ADD:
            begin
                if (!member)
                begin
                    swap_en  = 1'b1;
                    act_next = act_reg + CW'(1);
                    if (!stored)
                    begin
                        sw_x     = app_reg[EW-1:0];
                        app_next = app_reg + CW'(1);
                        if (act_reg == app_reg)
                        begin
                            sw_ey = elem_reg;
                        end
                    end
                end
            end
            bss_pkg::K_REMOVE:
            begin
                if (!member)
                begin
                    res.status = bss_pkg::STATUS_INVALID;
                end
                else
                begin
                    swap_en  = 1'b1;
                    act_next = act_m1;
                    sw_y     = act_m1[EW-1:0];
                end
            end
            bss_pkg::K_CONTAIN:
            begin
                res.found = member;
            end
            bss_pkg::K_RESTORE:
            begin
                if (pos_reg > app_reg)
                begin
                    res.status = bss_pkg::STATUS_INVALID;
                end
                else
                begin
                    act_next = pos_reg;
                end
            end
            bss_pkg::K_CLEAR:
            begin
                act_next = '0;
            end
            bss_pkg::K_FILL:
            begin
                act_next = app_reg;
            end
            bss_pkg::K_POP_BACK:
            begin
                if (act_reg == '0)
                begin
                    res.status = bss_pkg::STATUS_INVALID;
                end
                else
                begin
                    act_next  = act_m1;
                    res.value = ld1_reg;
                end
            end
            bss_pkg::K_POP_HEAD:
            begin
                if (act_reg == '0)
                begin
                    res.status = bss_pkg::STATUS_INVALID;
                end
                else
                begin
                    swap_en   = 1'b1;
                    act_next  = act_m1;
                    res.value = ld1_reg;
                    sw_x      = '0;
                    sw_y      = act_m1[EW-1:0];
                    sw_ex     = ld1_reg;
                    sw_ey     = l_rdata;
                end
            end
            bss_pkg::K_NEXT:
            begin
                if (!stored)
                begin
                    res.status = bss_pkg::STATUS_INVALID;
                end
                else
                begin
                    res.value = (slot_p1 < act_reg) ? l_rdata : elem_reg;
                end
            end
            bss_pkg::K_PREV:
            begin
                if (!stored)
                begin
                    res.status = bss_pkg::STATUS_INVALID;
                end
                else
                begin
                    res.value = (slot_reg != '0) ? l_rdata : elem_reg;
                end
            end
            bss_pkg::K_READ_AT:
            begin
                if (pos_reg >= app_reg)
                begin
                    res.status = bss_pkg::STATUS_INVALID;
                end
                else
                begin
                    res.value = ld1_reg;
                end
            end
            bss_pkg::K_MOVE_UP:
            begin
                if (!stored || (pos_reg >= app_reg) || (pos_reg < slot_reg))
                begin
                    res.status = bss_pkg::STATUS_INVALID;
                end
                else
                begin
                    swap_en = 1'b1;
                    sw_y    = pos_reg[EW-1:0];
                end
            end
            default:
            begin
                res.status = bss_pkg::STATUS_INVALID;
            end
        endcase
        res.active_size   = act_next;
        res.stored_length = app_next;
    end

    // Memory port control per state.
    always_comb
    begin
        s_we    = 1'b0;
        s_waddr = '0;
        s_wdata = '0;
        s_re    = 1'b0;
        s_raddr = '0;
        l_we    = 1'b0;
        l_waddr = '0;
        l_wdata = '0;
        l_re    = 1'b0;
        l_raddr = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                s_we    = 1'b1;
                s_waddr = clr_idx_reg;
                s_wdata = bss_pkg::NEVER_ADDED;
                if (clr_idx_reg == bss_pkg::LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (acc)
                begin
                    s_re    = 1'b1;
                    s_raddr = req.element;
                    l_re    = 1'b1;
                    case (req.kind)
                        bss_pkg::K_ADD:      l_raddr = act_reg[EW-1:0];
                        bss_pkg::K_REMOVE:   l_raddr = act_m1[EW-1:0];
                        bss_pkg::K_POP_BACK: l_raddr = act_m1[EW-1:0];
                        bss_pkg::K_READ_AT:  l_raddr = req.position[EW-1:0];
                        bss_pkg::K_MOVE_UP:  l_raddr = req.position[EW-1:0];
                        default:             l_raddr = '0;
                    endcase
                    state_next = ST_RD2;
                end
            end
            ST_RD2:
            begin
                l_re = 1'b1;
                case (kind_reg)
                    bss_pkg::K_NEXT:     l_raddr = rd_slot_p1[EW-1:0];
                    bss_pkg::K_PREV:     l_raddr = rd_slot_m1[EW-1:0];
                    bss_pkg::K_POP_HEAD: l_raddr = act_m1[EW-1:0];
                    default:             l_raddr = '0;
                endcase
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (swap_en)
                begin
                    l_we       = 1'b1;
                    l_waddr    = sw_x;
                    l_wdata    = sw_ey;
                    s_we       = 1'b1;
                    s_waddr    = sw_ey;
                    s_wdata    = CW'(sw_x);
                    state_next = ST_WR2;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WR2:
            begin
                l_we       = 1'b1;
                l_waddr    = w2_addr_reg;
                l_wdata    = w2_elem_reg;
                s_we       = 1'b1;
                s_waddr    = w2_elem_reg;
                s_wdata    = CW'(w2_addr_reg);
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            act_reg     <= '0;
            app_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + EW'(1);
            end
            if (state_reg == ST_EXEC)
            begin
                act_reg <= act_next;
                app_reg <= app_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            kind_reg <= req.kind;
            elem_reg <= req.element;
            pos_reg  <= req.position;
        end
        if (state_reg == ST_RD2)
        begin
            slot_reg <= s_rdata;
            ld1_reg  <= l_rdata;
        end
        if (state_reg == ST_EXEC)
        begin
            w2_addr_reg <= sw_y;
            w2_elem_reg <= sw_ex;
        end
    end

    a_act_le_app: assert property (@(posedge clk) disable iff (!rst_n)
        act_reg <= app_reg)
        else $error("active count exceeds stored length");

    a_app_bound: assert property (@(posedge clk) disable iff (!rst_n)
        app_reg <= bss_pkg::NEVER_ADDED)
        else $error("stored length exceeds universe");

    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> (state_reg == ST_RD2) ##1 (state_reg == ST_EXEC))
        else $error("transaction did not advance through read stages");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (l_we || s_we) |-> !(l_re || s_re))
        else $error("memory read issued during a write cycle");

endmodule

`default_nettype wire

### rtl/backtrackable_sparse_set.sv
// Top level of the backtrackable sparse set.
// Flow: an accepted request passes RD2 and EXEC; in EXEC its result enters the output
// register, or the skid entry if the response stalls. A new request is taken only in IDLE
// with buffer room; add, remove, head pop and move_up that swap also write in WR2.
// Reset: counts clear at once; a pass in the clear state then marks every element never
// added, with request ready held low until it ends.
`timescale 1ns / 1ps
`default_nettype none

module backtrackable_sparse_set (
    input  wire logic clk,
    input  wire logic rst_n,
    bss_in_if.sink    req,
    bss_out_if.source rsp
);

    localparam int EW = bss_pkg::ELEM_W;
    localparam int CW = bss_pkg::CNT_W;

    logic          room;
    logic          push;
    bss_pkg::res_t res;
    logic          s_we;
    logic [EW-1:0] s_waddr;
    logic [CW-1:0] s_wdata;
    logic          s_re;
    logic [EW-1:0] s_raddr;
    logic [CW-1:0] s_rdata;
    logic          l_we;
    logic [EW-1:0] l_waddr;
    logic [EW-1:0] l_wdata;
    logic          l_re;
    logic [EW-1:0] l_raddr;
    logic [EW-1:0] l_rdata;

    bss_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .room    (room),
        .push    (push),
        .res     (res),
        .s_we    (s_we),
        .s_waddr (s_waddr),
        .s_wdata (s_wdata),
        .s_re    (s_re),
        .s_raddr (s_raddr),
        .s_rdata (s_rdata),
        .l_we    (l_we),
        .l_waddr (l_waddr),
        .l_wdata (l_wdata),
        .l_re    (l_re),
        .l_raddr (l_raddr),
        .l_rdata (l_rdata)
    );

    bss_ram #(
        .DEPTH (bss_pkg::UNIVERSE),
        .WIDTH (CW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    bss_ram #(
        .DEPTH (bss_pkg::UNIVERSE),
        .WIDTH (EW)
    ) u_list_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (l_re),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    bss_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (res),
        .room  (room),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire
